/* sv/assert_macros.svh */
// assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SVPWM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define SVPWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define SVPWM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define SVPWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* sv/svpwm_pkg.sv */
package svpwm_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FRAC    = 30;
  // q6.30 intermediates with headroom for the clarke and offset sums
  localparam int QW      = 36;
  localparam int BETA_W  = 33;
  localparam int SQ3_W   = 32;
  localparam int PROD_W  = BETA_W + SQ3_W;
  localparam int DUTY_W  = 16;
  localparam logic signed [SQ3_W-1:0] SQ3 = 32'sd1859775393;

  typedef struct packed {
    logic signed [QW-1:0] alpha;
    logic signed [QW-1:0] beta;
  } ab_t;

  typedef struct packed {
    logic signed [QW-1:0] w1;
    logic signed [QW-1:0] w2;
    logic signed [QW-1:0] w3;
  } wave_t;

endpackage

/* sv/svpwm_duty_from_dq_core.sv */
// space-vector pwm duty generator, min-max zero-sequence injection
// input channel: in_valid_i / in_ready_o carry one d/q command with the
//   sine and cosine of the electrical angle, all signed q1.(SAMPLE_WIDTH-1)
// output channel: out_valid_o / out_ready_i carry the three bridge duties,
//   unsigned q0.16, 32768 at midpoint, 65535 at full scale
// every transaction in gives exactly one transaction out, in order
// each input accept reaches its output through six register stages
//   (park products, alpha/beta, sqrt3 product, three waves, min-max
//   offset, clamp and duty output register)
// throughput: one transaction per cycle while the receiver does not stall;
//   each stage takes a new transaction in the same cycle that it passes one on
// reset clears every stage valid bit; payload registers are not reset
// when the receiver stalls the stages fill behind the output register and
//   in_ready_o drops only once all six stages hold a transaction
module svpwm_duty_from_dq_core #(
  parameter int SAMPLE_WIDTH = svpwm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]    volt_d_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    volt_q_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    angle_sine_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    angle_cosine_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [svpwm_pkg::DUTY_W-1:0]      duty_a_o,
  output logic [svpwm_pkg::DUTY_W-1:0]      duty_b_o,
  output logic [svpwm_pkg::DUTY_W-1:0]      duty_c_o
);

  `include "assert_macros.svh"

  logic             ab_valid, ab_ready;
  svpwm_pkg::ab_t   ab;
  logic             wave_valid, wave_ready;
  svpwm_pkg::wave_t wave;

  svpwm_park #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_park (
    .clk_i,
    .rst_ni,
    .valid_i        (in_valid_i),
    .ready_o        (in_ready_o),
    .volt_d_i,
    .volt_q_i,
    .angle_sine_i,
    .angle_cosine_i,
    .valid_o        (ab_valid),
    .ready_i        (ab_ready),
    .ab_o           (ab)
  );

  svpwm_clarke u_clarke (
    .clk_i,
    .rst_ni,
    .valid_i (ab_valid),
    .ready_o (ab_ready),
    .ab_i    (ab),
    .valid_o (wave_valid),
    .ready_i (wave_ready),
    .wave_o  (wave)
  );

  svpwm_inject u_inject (
    .clk_i,
    .rst_ni,
    .valid_i  (wave_valid),
    .ready_o  (wave_ready),
    .wave_i   (wave),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .duty_a_o,
    .duty_b_o,
    .duty_c_o
  );

  // backpressure reaches the input only with the whole pipe full and stalled
  `SVPWM_ASSERT_IMPL(in_ready_full_a, clk_i, rst_ni, !in_ready_o,
                     out_valid_o && !out_ready_i && ab_valid && wave_valid,
                     "input stalled while pipeline had room")

endmodule

/* sv/svpwm_park.sv */
`include "assert_macros.svh"

module svpwm_park #(
  parameter int SAMPLE_WIDTH = svpwm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] volt_d_i,
  input  logic signed [SAMPLE_WIDTH-1:0] volt_q_i,
  input  logic signed [SAMPLE_WIDTH-1:0] angle_sine_i,
  input  logic signed [SAMPLE_WIDTH-1:0] angle_cosine_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output svpwm_pkg::ab_t                 ab_o
);

  localparam int QW = svpwm_pkg::QW;
  localparam int PW = 2 * SAMPLE_WIDTH;
  localparam int FB = 2 * (SAMPLE_WIDTH - 1);
  localparam int RS = (FB > svpwm_pkg::FRAC) ? FB - svpwm_pkg::FRAC : 0;
  localparam int LS = (FB < svpwm_pkg::FRAC) ? svpwm_pkg::FRAC - FB : 0;
  localparam int EW = PW + LS + 2;
  localparam logic [EW-1:0] HALF = EW'((64'd1 << RS) >> 1);

  logic va_q, vb_q;
  logic rdy_a, rdy_b;
  logic signed [PW-1:0] p_dc_q, p_qs_q, p_ds_q, p_qc_q;
  svpwm_pkg::ab_t ab_q;

  // rescale a raw sample product to 30 fraction bits, round half up
  function automatic logic signed [QW-1:0] to_q30(input logic signed [PW-1:0] p);
    logic signed [EW-1:0] x;
    x = EW'(p);
    x = x <<< LS;
    x = x + $signed(HALF);
    return QW'(x >>> RS);
  endfunction

  assign rdy_b   = !vb_q || ready_i;
  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;
  assign valid_o = vb_q;
  assign ab_o    = ab_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= valid_i;
      if (rdy_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      p_dc_q <= volt_d_i * angle_cosine_i;
      p_qs_q <= volt_q_i * angle_sine_i;
      p_ds_q <= volt_d_i * angle_sine_i;
      p_qc_q <= volt_q_i * angle_cosine_i;
    end
    if (rdy_b && va_q) begin
      ab_q.alpha <= to_q30(p_dc_q) - to_q30(p_qs_q);
      ab_q.beta  <= to_q30(p_ds_q) + to_q30(p_qc_q);
    end
  end

  `SVPWM_ASSERT_NEXT(park_hold_a, clk_i, rst_ni, vb_q && !ready_i, vb_q && $stable(ab_q),
                     "park output changed while stalled")

endmodule

/* sv/svpwm_clarke.sv */
`include "assert_macros.svh"

module svpwm_clarke (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  svpwm_pkg::ab_t   ab_i,
  output logic             valid_o,
  input  logic             ready_i,
  output svpwm_pkg::wave_t wave_o
);

  localparam int QW     = svpwm_pkg::QW;
  localparam int PROD_W = svpwm_pkg::PROD_W;
  localparam int BETA_W = svpwm_pkg::BETA_W;
  localparam int FRAC   = svpwm_pkg::FRAC;
  localparam logic signed [PROD_W-1:0] RND = PROD_W'(1) <<< (FRAC - 1);

  logic vc_q, vd_q;
  logic rdy_c, rdy_d;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [QW-1:0]     alpha_q;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [QW-1:0]     t;
  svpwm_pkg::wave_t         wave_q;

  assign rdy_d   = !vd_q || ready_i;
  assign rdy_c   = !vc_q || rdy_d;
  assign ready_o = rdy_c;
  assign valid_o = vd_q;
  assign wave_o  = wave_q;

  assign prod_rnd = prod_q + RND;
  assign t        = QW'(prod_rnd >>> FRAC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (rdy_c) vc_q <= valid_i;
      if (rdy_d) vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && valid_i) begin
      // beta stays within 33 bits, so the top bits are sign copies
      prod_q  <= $signed(ab_i.beta[BETA_W-1:0]) * svpwm_pkg::SQ3;
      alpha_q <= ab_i.alpha;
    end
    if (rdy_d && vc_q) begin
      wave_q.w1 <= alpha_q;
      wave_q.w2 <= (t - alpha_q + QW'(1)) >>> 1;
      wave_q.w3 <= (-t - alpha_q + QW'(1)) >>> 1;
    end
  end

  // both halves round the same way, so the three waves sum to zero or one
  `SVPWM_ASSERT_IMPL(wave_sum_a, clk_i, rst_ni, vd_q,
                     (wave_q.w1 + wave_q.w2 + wave_q.w3) == 0 ||
                     (wave_q.w1 + wave_q.w2 + wave_q.w3) == 1,
                     "three-phase waves do not balance")

endmodule

/* sv/svpwm_inject.sv */
module svpwm_inject (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  svpwm_pkg::wave_t                   wave_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic [svpwm_pkg::DUTY_W-1:0]       duty_a_o,
  output logic [svpwm_pkg::DUTY_W-1:0]       duty_b_o,
  output logic [svpwm_pkg::DUTY_W-1:0]       duty_c_o
);

  localparam int QW     = svpwm_pkg::QW;
  localparam int DUTY_W = svpwm_pkg::DUTY_W;
  localparam int FRAC   = svpwm_pkg::FRAC;
  localparam int DSH    = FRAC - (DUTY_W - 1);
  localparam logic signed [QW:0] ONE  = (QW+1)'(1) <<< FRAC;
  localparam logic signed [QW:0] DRND = (QW+1)'(1) <<< (DSH - 1);
  localparam logic signed [QW:0] DMAX = ((QW+1)'(1) <<< DUTY_W) - (QW+1)'(1);

  logic ve_q, vf_q;
  logic rdy_e, rdy_f;
  logic signed [QW-1:0] hi, lo;
  logic signed [QW:0]   hl;
  svpwm_pkg::wave_t     wave_q;
  logic signed [QW-1:0] off_q;
  logic [DUTY_W-1:0]    da_q, db_q, dc_q;

  // clamp to [-1,1] and map onto [0,1] duty with full scale saturated
  function automatic logic [DUTY_W-1:0] to_duty(input logic signed [QW-1:0] w,
                                                input logic signed [QW-1:0] off);
    logic signed [QW:0] s;
    logic signed [QW:0] d;
    s = w + off;
    if (s > ONE) s = ONE;
    else if (s < -ONE) s = -ONE;
    d = (s + ONE + DRND) >>> DSH;
    if (d > DMAX) d = DMAX;
    return d[DUTY_W-1:0];
  endfunction

  always_comb begin
    hi = wave_i.w1;
    if (wave_i.w2 > hi) hi = wave_i.w2;
    if (wave_i.w3 > hi) hi = wave_i.w3;
    lo = wave_i.w1;
    if (wave_i.w2 < lo) lo = wave_i.w2;
    if (wave_i.w3 < lo) lo = wave_i.w3;
  end

  assign hl = hi + lo;

  assign rdy_f    = !vf_q || ready_i;
  assign rdy_e    = !ve_q || rdy_f;
  assign ready_o  = rdy_e;
  assign valid_o  = vf_q;
  assign duty_a_o = da_q;
  assign duty_b_o = db_q;
  assign duty_c_o = dc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else begin
      if (rdy_e) ve_q <= valid_i;
      if (rdy_f) vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_e && valid_i) begin
      wave_q <= wave_i;
      off_q  <= QW'((-hl + (QW+1)'(1)) >>> 1);
    end
    if (rdy_f && ve_q) begin
      da_q <= to_duty(wave_q.w1, off_q);
      db_q <= to_duty(wave_q.w2, off_q);
      dc_q <= to_duty(wave_q.w3, off_q);
    end
  end

endmodule
